// File: hw/rtl/tlik_pkg.sv
// shared types, constants and the arctangent table for the two-link arm solver
// used by tlik_ctrl, tlik_dp and two_link_arm_inverse_kinematics
// no dependencies
package tlik_pkg;

   // default parameter values
   localparam int ANGLE_FRAC_BITS_DEF = 12;
   localparam int COORD_WIDTH_DEF     = 12;

   // field widths
   localparam int STEP_W = 7;
   localparam int LEN_W  = 10;
   localparam int HOME_W = 12;
   localparam int EL_W   = 11;
   localparam int TIP_W  = 12;
   localparam int DATA_W = 12;
   localparam int IDX_W  = 2;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_UPPER_LEN = 2'd0;
   localparam logic [IDX_W-1:0] CSR_LOWER_LEN = 2'd1;
   localparam logic [IDX_W-1:0] CSR_HOME_X    = 2'd2;
   localparam logic [IDX_W-1:0] CSR_HOME_Y    = 2'd3;

   // register reset values
   localparam logic [LEN_W-1:0]         UPPER_LEN_RESET = 10'd330;
   localparam logic [LEN_W-1:0]         LOWER_LEN_RESET = 10'd350;
   localparam logic signed [HOME_W-1:0] HOME_X_RESET    = 12'sd350;
   localparam logic signed [HOME_W-1:0] HOME_Y_RESET    = -12'sd240;

   // internal datapath widths
   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DEN_W  = 22;
   localparam int NUM_W  = 23;
   localparam int RAD_W  = 48;
   localparam int S_W    = 24;
   localparam int IN_W   = 36;
   localparam int VW     = 58;
   localparam int ZW     = 30;

   // cordic constants, angles in units of 2^-24 rad
   localparam int CORDIC_FRAC = 24;
   localparam int VEC_SHIFT   = 20;
   localparam int Q30_SHIFT   = 30;
   localparam int ITER_W      = 5;
   localparam logic [ITER_W-1:0] ITER_LAST = 5'd23;
   localparam logic [ITER_W-1:0] WRAP_LAST = 5'd1;
   localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;
   localparam logic signed [ZW-1:0] PI_I      = 30'sd52707179;
   localparam logic signed [ZW-1:0] HALF_PI_I = 30'sd26353589;
   localparam logic signed [ZW-1:0] TWO_PI_I  = 30'sd105414357;

   // operand selects
   localparam int SEL_W = 2;
   localparam logic [SEL_W-1:0] VSEL_ACOS   = 2'd0;
   localparam logic [SEL_W-1:0] VSEL_TARGET = 2'd1;
   localparam logic [SEL_W-1:0] VSEL_LINK   = 2'd2;
   localparam logic [SEL_W-1:0] RSEL_UPPER  = 2'd0;
   localparam logic [SEL_W-1:0] RSEL_LOWER  = 2'd1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_L1,
      OP_SQ_L2,
      OP_DEN,
      OP_RAD,
      OP_SQRT_STEP,
      OP_PQ1,
      OP_PQ2,
      OP_LS,
      OP_VEC_LOAD,
      OP_VEC_STEP,
      OP_VEC_STORE,
      OP_ANGLES,
      OP_ROT_LOAD,
      OP_ROT_WRAP,
      OP_ROT_FOLD,
      OP_ROT_STEP,
      OP_ROT_STORE,
      OP_COMMIT,
      OP_OUTPUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [ITER_W-1:0] iter;
      logic [SEL_W-1:0]  sel;
   } dp_cmd_type;

   typedef struct packed {
      logic reach;
   } dp_status_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [ITER_W-1:0] i);
      logic signed [ZW-1:0] r;
      unique case (i)
         5'd0:  r = 30'sd13176795;
         5'd1:  r = 30'sd7778716;
         5'd2:  r = 30'sd4110060;
         5'd3:  r = 30'sd2086331;
         5'd4:  r = 30'sd1047214;
         5'd5:  r = 30'sd524117;
         5'd6:  r = 30'sd262123;
         5'd7:  r = 30'sd131069;
         5'd8:  r = 30'sd65536;
         5'd9:  r = 30'sd32768;
         5'd10: r = 30'sd16384;
         5'd11: r = 30'sd8192;
         5'd12: r = 30'sd4096;
         5'd13: r = 30'sd2048;
         5'd14: r = 30'sd1024;
         5'd15: r = 30'sd512;
         5'd16: r = 30'sd256;
         5'd17: r = 30'sd128;
         5'd18: r = 30'sd64;
         5'd19: r = 30'sd32;
         5'd20: r = 30'sd16;
         5'd21: r = 30'sd8;
         5'd22: r = 30'sd4;
         5'd23: r = 30'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/tlik_ctrl.sv
// sequencer for the arm solver: steps the datapath through squares, root,
// three vectoring and two rotation cordic passes; owns both handshakes
// depends on tlik_pkg
module tlik_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tlik_pkg::dp_cmd_type    cmd,
   input  tlik_pkg::dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_L1, S_SQ_L2, S_DEN, S_CHECK, S_RAD, S_SQRT,
      S_PQ1, S_PQ2, S_LS, S_VLOAD, S_VSTEP, S_VSTORE, S_ANGLES, S_RLOAD,
      S_RWRAP, S_RFOLD, S_RSTEP, S_RSTORE, S_COMMIT, S_DONE
   } state_type;

   state_type                       state_ff;
   logic [tlik_pkg::ITER_W-1:0]     iter_ff;
   logic [tlik_pkg::SEL_W-1:0]      sel_ff;
   logic                            rsp_valid_ff;
   logic                            out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_SQ_X;
               end
            end
            S_SQ_X:  state_ff <= S_SQ_Y;
            S_SQ_Y:  state_ff <= S_SQ_L1;
            S_SQ_L1: state_ff <= S_SQ_L2;
            S_SQ_L2: state_ff <= S_DEN;
            S_DEN:   state_ff <= S_CHECK;
            S_CHECK: begin
               state_ff <= status.reach ? S_RAD : S_DONE;
            end
            S_RAD: begin
               iter_ff  <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               if (iter_ff == tlik_pkg::ITER_LAST) begin
                  state_ff <= S_PQ1;
               end else begin
                  iter_ff <= iter_ff + 5'd1;
               end
            end
            S_PQ1: state_ff <= S_PQ2;
            S_PQ2: state_ff <= S_LS;
            S_LS: begin
               sel_ff   <= tlik_pkg::VSEL_ACOS;
               state_ff <= S_VLOAD;
            end
            S_VLOAD: begin
               iter_ff  <= '0;
               state_ff <= S_VSTEP;
            end
            S_VSTEP: begin
               if (iter_ff == tlik_pkg::ITER_LAST) begin
                  state_ff <= S_VSTORE;
               end else begin
                  iter_ff <= iter_ff + 5'd1;
               end
            end
            S_VSTORE: begin
               if (sel_ff == tlik_pkg::VSEL_LINK) begin
                  state_ff <= S_ANGLES;
               end else begin
                  sel_ff   <= sel_ff + 2'd1;
                  state_ff <= S_VLOAD;
               end
            end
            S_ANGLES: begin
               sel_ff   <= tlik_pkg::RSEL_UPPER;
               state_ff <= S_RLOAD;
            end
            S_RLOAD: begin
               iter_ff  <= '0;
               state_ff <= S_RWRAP;
            end
            S_RWRAP: begin
               if (iter_ff == tlik_pkg::WRAP_LAST) begin
                  state_ff <= S_RFOLD;
               end else begin
                  iter_ff <= iter_ff + 5'd1;
               end
            end
            S_RFOLD: begin
               iter_ff  <= '0;
               state_ff <= S_RSTEP;
            end
            S_RSTEP: begin
               if (iter_ff == tlik_pkg::ITER_LAST) begin
                  state_ff <= S_RSTORE;
               end else begin
                  iter_ff <= iter_ff + 5'd1;
               end
            end
            S_RSTORE: begin
               if (sel_ff == tlik_pkg::RSEL_LOWER) begin
                  state_ff <= S_COMMIT;
               end else begin
                  sel_ff   <= sel_ff + 2'd1;
                  state_ff <= S_RLOAD;
               end
            end
            S_COMMIT: state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

   always_comb begin
      cmd.iter = iter_ff;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_valid ? tlik_pkg::OP_ACCEPT : tlik_pkg::OP_NONE;
         S_SQ_X:   cmd.op = tlik_pkg::OP_SQ_X;
         S_SQ_Y:   cmd.op = tlik_pkg::OP_SQ_Y;
         S_SQ_L1:  cmd.op = tlik_pkg::OP_SQ_L1;
         S_SQ_L2:  cmd.op = tlik_pkg::OP_SQ_L2;
         S_DEN:    cmd.op = tlik_pkg::OP_DEN;
         S_CHECK:  cmd.op = tlik_pkg::OP_NONE;
         S_RAD:    cmd.op = tlik_pkg::OP_RAD;
         S_SQRT:   cmd.op = tlik_pkg::OP_SQRT_STEP;
         S_PQ1:    cmd.op = tlik_pkg::OP_PQ1;
         S_PQ2:    cmd.op = tlik_pkg::OP_PQ2;
         S_LS:     cmd.op = tlik_pkg::OP_LS;
         S_VLOAD:  cmd.op = tlik_pkg::OP_VEC_LOAD;
         S_VSTEP:  cmd.op = tlik_pkg::OP_VEC_STEP;
         S_VSTORE: cmd.op = tlik_pkg::OP_VEC_STORE;
         S_ANGLES: cmd.op = tlik_pkg::OP_ANGLES;
         S_RLOAD:  cmd.op = tlik_pkg::OP_ROT_LOAD;
         S_RWRAP:  cmd.op = tlik_pkg::OP_ROT_WRAP;
         S_RFOLD:  cmd.op = tlik_pkg::OP_ROT_FOLD;
         S_RSTEP:  cmd.op = tlik_pkg::OP_ROT_STEP;
         S_RSTORE: cmd.op = tlik_pkg::OP_ROT_STORE;
         S_COMMIT: cmd.op = tlik_pkg::OP_COMMIT;
         S_DONE:   cmd.op = out_free ? tlik_pkg::OP_OUTPUT : tlik_pkg::OP_NONE;
      endcase
   end

endmodule

// File: hw/rtl/tlik_dp.sv
// datapath for the arm solver: target registers, shared multiplier, bitwise
// square root, shared cordic, held solution and result register
// depends on tlik_pkg
module tlik_dp #(
   parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int COORD_WIDTH     = tlik_pkg::COORD_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  tlik_pkg::dp_cmd_type                      cmd,
   output tlik_pkg::dp_status_type                   status,
   input  logic signed [tlik_pkg::STEP_W-1:0]        step_x,
   input  logic signed [tlik_pkg::STEP_W-1:0]        step_y,
   input  logic                                      return_home,
   input  logic [tlik_pkg::LEN_W-1:0]                upper_len,
   input  logic [tlik_pkg::LEN_W-1:0]                lower_len,
   input  logic signed [tlik_pkg::HOME_W-1:0]        home_x,
   input  logic signed [tlik_pkg::HOME_W-1:0]        home_y,
   output logic                                      out_reachable,
   output logic signed [ANGLE_FRAC_BITS+3:0]         out_shoulder,
   output logic signed [ANGLE_FRAC_BITS+2:0]         out_elbow,
   output logic signed [tlik_pkg::EL_W-1:0]          out_elbow_x,
   output logic signed [tlik_pkg::EL_W-1:0]          out_elbow_y,
   output logic signed [tlik_pkg::TIP_W-1:0]         out_tip_x,
   output logic signed [tlik_pkg::TIP_W-1:0]         out_tip_y
);

   localparam int CW   = COORD_WIDTH;
   localparam int AW   = 2 * COORD_WIDTH + 4;
   localparam int SH   = tlik_pkg::CORDIC_FRAC - ANGLE_FRAC_BITS;
   localparam int SHW  = ANGLE_FRAC_BITS + 4;
   localparam int ELW  = ANGLE_FRAC_BITS + 3;
   localparam int MW   = tlik_pkg::MUL_W;
   localparam int VW   = tlik_pkg::VW;
   localparam int ZW   = tlik_pkg::ZW;
   localparam int IW   = tlik_pkg::IN_W;
   localparam int RW   = tlik_pkg::RAD_W;
   localparam int LW   = tlik_pkg::LEN_W;
   localparam int EW   = tlik_pkg::EL_W;
   localparam int TW   = tlik_pkg::TIP_W;
   localparam int SATW = 17;
   localparam int C_HI_I = (1 << (CW - 1)) - 1;
   localparam logic signed [SATW-1:0] C_HI = SATW'(C_HI_I);
   localparam logic signed [SATW-1:0] C_LO = SATW'(-C_HI_I - 1);
   localparam logic signed [ZW-1:0]   RND  = ZW'(1 << (SH - 1));

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [SATW-1:0] v);
      logic signed [SATW-1:0] r;
      if (v > C_HI) begin
         r = C_HI;
      end else if (v < C_LO) begin
         r = C_LO;
      end else begin
         r = v;
      end
      return r[CW-1:0];
   endfunction

   function automatic logic signed [EW-1:0] trunc_clamp(input logic signed [VW-1:0] v,
                                                        input logic [LW-1:0] len);
      logic signed [VW-1:0] t;
      logic signed [VW-1:0] lv;
      lv = VW'($signed({1'b0, len}));
      if (v >= 0) begin
         t = v >>> tlik_pkg::Q30_SHIFT;
      end else begin
         t = -((-v) >>> tlik_pkg::Q30_SHIFT);
      end
      if (t > lv) begin
         t = lv;
      end else if (t < -lv) begin
         t = -lv;
      end
      return t[EW-1:0];
   endfunction

   // target and solver registers
   logic signed [CW-1:0]               tx_ff, ty_ff;
   logic signed [AW-1:0]               acc_ff;
   logic [tlik_pkg::DEN_W-1:0]         den_ff;
   logic [RW-1:0]                      rem_ff, root_ff;
   logic signed [IW-1:0]               pq_ff, ls_ff;
   logic signed [VW-1:0]               vx_ff, vy_ff;
   logic signed [ZW-1:0]               vz_ff;
   logic                               vzero_ff, neg_ff;
   logic [LW-1:0]                      rlen_ff;
   logic signed [ZW-1:0]               t2_ff, p1_ff, p2_ff, q1_ff, q2_ff;
   logic signed [EW-1:0]               ex_ff, ey_ff, fx_ff, fy_ff;
   logic signed [SHW-1:0]              hq1_ff;
   logic signed [ELW-1:0]              hq2_ff;
   logic signed [EW-1:0]               hex_ff, hey_ff;
   logic signed [TW-1:0]               htx_ff, hty_ff;

   logic signed [CW:0]                 ay;
   logic signed [tlik_pkg::NUM_W-1:0]  num_s;
   logic signed [AW-1:0]               den_a;
   logic signed [MW-1:0]               den_m, num_m, mul_a, mul_b;
   logic signed [tlik_pkg::PROD_W-1:0] prod;
   logic [5:0]                         sq_sh;
   logic [RW-1:0]                      sq_bit, sq_trial;
   logic signed [IW-1:0]               vin_x, vin_y;
   logic signed [VW-1:0]               xs0, ys0, vshx, vshy, rx, ry;
   logic signed [ZW-1:0]               atan_i, zsel, zres;
   logic [LW-1:0]                      rlen;
   logic [LW+29:0]                     gain_prod;

   assign ay    = -((CW+1)'(ty_ff));
   assign num_s = acc_ff[tlik_pkg::NUM_W-1:0];
   assign den_a = AW'($signed({1'b0, den_ff}));
   assign status.reach = (den_ff != '0) && (acc_ff <= den_a) && (acc_ff >= -den_a);

   // shared multiplier
   assign den_m = MW'($signed({1'b0, den_ff}));
   assign num_m = MW'(num_s);
   always_comb begin
      unique case (cmd.op)
         tlik_pkg::OP_SQ_X: begin
            mul_a = MW'(tx_ff);
            mul_b = MW'(tx_ff);
         end
         tlik_pkg::OP_SQ_Y: begin
            mul_a = MW'(ay);
            mul_b = MW'(ay);
         end
         tlik_pkg::OP_SQ_L1: begin
            mul_a = MW'($signed({1'b0, upper_len}));
            mul_b = MW'($signed({1'b0, upper_len}));
         end
         tlik_pkg::OP_SQ_L2: begin
            mul_a = MW'($signed({1'b0, lower_len}));
            mul_b = MW'($signed({1'b0, lower_len}));
         end
         tlik_pkg::OP_DEN: begin
            mul_a = MW'($signed({1'b0, upper_len}));
            mul_b = MW'($signed({1'b0, lower_len}));
         end
         tlik_pkg::OP_RAD: begin
            mul_a = den_m - num_m;
            mul_b = den_m + num_m;
         end
         tlik_pkg::OP_PQ1: begin
            mul_a = MW'($signed({1'b0, upper_len}));
            mul_b = den_m;
         end
         tlik_pkg::OP_PQ2: begin
            mul_a = MW'($signed({1'b0, lower_len}));
            mul_b = num_m;
         end
         tlik_pkg::OP_LS: begin
            mul_a = MW'($signed({1'b0, lower_len}));
            mul_b = MW'($signed({1'b0, root_ff[tlik_pkg::S_W-1:0]}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // square root, one result bit per step
   assign sq_sh    = 6'((int'(tlik_pkg::ITER_LAST) - int'(cmd.iter)) * 2);
   assign sq_bit   = RW'(1) << sq_sh;
   assign sq_trial = root_ff + sq_bit;

   // vectoring operand select
   always_comb begin
      unique case (cmd.sel)
         tlik_pkg::VSEL_ACOS: begin
            vin_y = IW'($signed({1'b0, root_ff[tlik_pkg::S_W-1:0]}));
            vin_x = IW'(num_s);
         end
         tlik_pkg::VSEL_TARGET: begin
            vin_y = IW'(ay);
            vin_x = IW'(tx_ff);
         end
         default: begin
            vin_y = -ls_ff;
            vin_x = pq_ff;
         end
      endcase
   end
   assign xs0 = VW'(vin_x) <<< tlik_pkg::VEC_SHIFT;
   assign ys0 = VW'(vin_y) <<< tlik_pkg::VEC_SHIFT;

   assign vshx   = vx_ff >>> cmd.iter;
   assign vshy   = vy_ff >>> cmd.iter;
   assign atan_i = tlik_pkg::atan_entry(cmd.iter);
   assign zres   = vzero_ff ? '0 : vz_ff;

   // rotation setup
   assign rlen      = (cmd.sel == tlik_pkg::RSEL_LOWER) ? lower_len : upper_len;
   assign zsel      = (cmd.sel == tlik_pkg::RSEL_LOWER) ? ((q1_ff + q2_ff) <<< SH)
                                                        : (q1_ff <<< SH);
   assign gain_prod = rlen * tlik_pkg::GAIN_INV_Q30;
   assign rx        = neg_ff ? -vx_ff : vx_ff;
   assign ry        = neg_ff ? -vy_ff : vy_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff  <= sat_coord(SATW'(tlik_pkg::HOME_X_RESET));
         ty_ff  <= sat_coord(SATW'(tlik_pkg::HOME_Y_RESET));
         hq1_ff <= '0;
         hq2_ff <= '0;
         hex_ff <= '0;
         hey_ff <= '0;
         htx_ff <= '0;
         hty_ff <= '0;
      end else if (cmd.op == tlik_pkg::OP_ACCEPT) begin
         if (return_home) begin
            tx_ff <= sat_coord(SATW'(home_x));
            ty_ff <= sat_coord(SATW'(home_y));
         end else begin
            tx_ff <= sat_coord(SATW'(tx_ff) + SATW'(step_x));
            ty_ff <= sat_coord(SATW'(ty_ff) + SATW'(step_y));
         end
      end else if (cmd.op == tlik_pkg::OP_COMMIT) begin
         hq1_ff <= q1_ff[SHW-1:0];
         hq2_ff <= q2_ff[ELW-1:0];
         hex_ff <= ex_ff;
         hey_ff <= ey_ff;
         htx_ff <= TW'(ex_ff) + TW'(fx_ff);
         hty_ff <= TW'(ey_ff) + TW'(fy_ff);
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         tlik_pkg::OP_SQ_X:  acc_ff <= AW'(prod);
         tlik_pkg::OP_SQ_Y:  acc_ff <= acc_ff + AW'(prod);
         tlik_pkg::OP_SQ_L1: acc_ff <= acc_ff - AW'(prod);
         tlik_pkg::OP_SQ_L2: acc_ff <= acc_ff - AW'(prod);
         tlik_pkg::OP_DEN:   den_ff <= {prod[tlik_pkg::DEN_W-2:0], 1'b0};
         tlik_pkg::OP_RAD: begin
            rem_ff  <= prod[RW-1:0];
            root_ff <= '0;
         end
         tlik_pkg::OP_SQRT_STEP: begin
            if (rem_ff >= sq_trial) begin
               rem_ff  <= rem_ff - sq_trial;
               root_ff <= (root_ff >> 1) + sq_bit;
            end else begin
               root_ff <= root_ff >> 1;
            end
         end
         tlik_pkg::OP_PQ1: pq_ff <= IW'(prod);
         tlik_pkg::OP_PQ2: pq_ff <= pq_ff + IW'(prod);
         tlik_pkg::OP_LS:  ls_ff <= IW'(prod);
         tlik_pkg::OP_VEC_LOAD: begin
            vzero_ff <= (vin_x == '0) && (vin_y == '0);
            if (vin_x < 0) begin
               vz_ff <= (vin_y >= 0) ? tlik_pkg::PI_I : -tlik_pkg::PI_I;
               vx_ff <= -xs0;
               vy_ff <= -ys0;
            end else begin
               vz_ff <= '0;
               vx_ff <= xs0;
               vy_ff <= ys0;
            end
         end
         tlik_pkg::OP_VEC_STEP: begin
            if (vy_ff > 0) begin
               vx_ff <= vx_ff + vshy;
               vy_ff <= vy_ff - vshx;
               vz_ff <= vz_ff + atan_i;
            end else begin
               vx_ff <= vx_ff - vshy;
               vy_ff <= vy_ff + vshx;
               vz_ff <= vz_ff - atan_i;
            end
         end
         tlik_pkg::OP_VEC_STORE: begin
            unique case (cmd.sel)
               tlik_pkg::VSEL_ACOS:   t2_ff <= -zres;
               tlik_pkg::VSEL_TARGET: p1_ff <= zres;
               default:               p2_ff <= zres;
            endcase
         end
         tlik_pkg::OP_ANGLES: begin
            q1_ff <= (p1_ff - p2_ff + RND) >>> SH;
            q2_ff <= (t2_ff + RND) >>> SH;
         end
         tlik_pkg::OP_ROT_LOAD: begin
            rlen_ff <= rlen;
            vz_ff   <= zsel;
            vx_ff   <= VW'($signed({1'b0, gain_prod}));
            vy_ff   <= '0;
            neg_ff  <= 1'b0;
         end
         tlik_pkg::OP_ROT_WRAP: begin
            if (vz_ff > tlik_pkg::PI_I) begin
               vz_ff <= vz_ff - tlik_pkg::TWO_PI_I;
            end else if (vz_ff < -tlik_pkg::PI_I) begin
               vz_ff <= vz_ff + tlik_pkg::TWO_PI_I;
            end
         end
         tlik_pkg::OP_ROT_FOLD: begin
            if (vz_ff > tlik_pkg::HALF_PI_I) begin
               vz_ff  <= vz_ff - tlik_pkg::PI_I;
               neg_ff <= 1'b1;
            end else if (vz_ff < -tlik_pkg::HALF_PI_I) begin
               vz_ff  <= vz_ff + tlik_pkg::PI_I;
               neg_ff <= 1'b1;
            end
         end
         tlik_pkg::OP_ROT_STEP: begin
            if (vz_ff >= 0) begin
               vx_ff <= vx_ff - vshy;
               vy_ff <= vy_ff + vshx;
               vz_ff <= vz_ff - atan_i;
            end else begin
               vx_ff <= vx_ff + vshy;
               vy_ff <= vy_ff - vshx;
               vz_ff <= vz_ff + atan_i;
            end
         end
         tlik_pkg::OP_ROT_STORE: begin
            if (cmd.sel == tlik_pkg::RSEL_LOWER) begin
               fx_ff <= trunc_clamp(rx, rlen_ff);
               fy_ff <= trunc_clamp(ry, rlen_ff);
            end else begin
               ex_ff <= trunc_clamp(rx, rlen_ff);
               ey_ff <= trunc_clamp(ry, rlen_ff);
            end
         end
         tlik_pkg::OP_OUTPUT: begin
            out_reachable <= status.reach;
            out_shoulder  <= hq1_ff;
            out_elbow     <= hq2_ff;
            out_elbow_x   <= hex_ff;
            out_elbow_y   <= hey_ff;
            out_tip_x     <= htx_ff;
            out_tip_y     <= hty_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hw/rtl/two_link_arm_inverse_kinematics.sv
// two-link arm inverse kinematics: a new request is taken only once the previous one
// has reached the result register; the time is set by one shared cordic that runs
// three 24-step vectoring passes and two 24-step rotation passes, after a 24-step
// bitwise square root
// an out-of-reach request skips the solver
// synchronous active-high reset: link lengths 330/350, home (350,-240), target at
// home, held solution zero, no result pending
module two_link_arm_inverse_kinematics #(
   parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int COORD_WIDTH     = tlik_pkg::COORD_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [tlik_pkg::STEP_W-1:0]       req_step_x,
   input  logic signed [tlik_pkg::STEP_W-1:0]       req_step_y,
   input  logic                                     req_return_home,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_reachable,
   output logic signed [ANGLE_FRAC_BITS+3:0]        rsp_shoulder_angle,
   output logic signed [ANGLE_FRAC_BITS+2:0]        rsp_elbow_angle,
   output logic signed [tlik_pkg::EL_W-1:0]         rsp_elbow_x,
   output logic signed [tlik_pkg::EL_W-1:0]         rsp_elbow_y,
   output logic signed [tlik_pkg::TIP_W-1:0]        rsp_tip_x,
   output logic signed [tlik_pkg::TIP_W-1:0]        rsp_tip_y,
   // register write port
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [tlik_pkg::IDX_W-1:0]               csr_index,
   input  logic [tlik_pkg::DATA_W-1:0]              csr_wdata
);

   // configuration registers
   logic [tlik_pkg::LEN_W-1:0]         upper_len_ff, lower_len_ff;
   logic signed [tlik_pkg::HOME_W-1:0] home_x_ff, home_y_ff;

   tlik_pkg::dp_cmd_type    cmd;
   tlik_pkg::dp_status_type status;

   // writes are always taken; software only writes while the block is idle, which the block does not enforce
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_len_ff <= tlik_pkg::UPPER_LEN_RESET;
         lower_len_ff <= tlik_pkg::LOWER_LEN_RESET;
         home_x_ff    <= tlik_pkg::HOME_X_RESET;
         home_y_ff    <= tlik_pkg::HOME_Y_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tlik_pkg::CSR_UPPER_LEN: upper_len_ff <= csr_wdata[tlik_pkg::LEN_W-1:0];
            tlik_pkg::CSR_LOWER_LEN: lower_len_ff <= csr_wdata[tlik_pkg::LEN_W-1:0];
            tlik_pkg::CSR_HOME_X:    home_x_ff    <= csr_wdata;
            tlik_pkg::CSR_HOME_Y:    home_y_ff    <= csr_wdata;
         endcase
      end
   end

   // sequencer: one request in flight, result register frees the input side
   tlik_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic: target update, reach test, root, cordic, held solution
   tlik_dp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .COORD_WIDTH     (COORD_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .step_x        (req_step_x),
      .step_y        (req_step_y),
      .return_home   (req_return_home),
      .upper_len     (upper_len_ff),
      .lower_len     (lower_len_ff),
      .home_x        (home_x_ff),
      .home_y        (home_y_ff),
      .out_reachable (rsp_reachable),
      .out_shoulder  (rsp_shoulder_angle),
      .out_elbow     (rsp_elbow_angle),
      .out_elbow_x   (rsp_elbow_x),
      .out_elbow_y   (rsp_elbow_y),
      .out_tip_x     (rsp_tip_x),
      .out_tip_y     (rsp_tip_y)
   );

endmodule

// File: bench/tb_two_link_arm_inverse_kinematics.sv
// self-checking bench for the two-link arm inverse kinematics block: directed table,
// then random jog runs over several link and home settings, checked by a built-in solver
// depends on tlik_pkg and two_link_arm_inverse_kinematics
module tb_two_link_arm_inverse_kinematics;
   timeunit 1ns;
   timeprecision 1ps;

   // solver constants, angles in units of 2^-24 rad
   localparam longint PI_A      = 52707179;
   localparam longint HALF_PI_A = 26353589;
   localparam longint TWO_PI_A  = 105414357;
   localparam longint INV_GAIN  = 652032874;
   localparam longint PRE_SCALE = 1048576;
   localparam int     N_ROT     = 24;
   localparam int     RND_ITEMS = 1850;
   localparam int     N_PHASES  = 8;
   localparam int     HOLD_OFF  = 700;

   localparam longint ARC_STEP [N_ROT] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};

   typedef struct packed {
      logic               reach;
      logic signed [15:0] shoulder;
      logic signed [14:0] elbow;
      logic signed [10:0] ex;
      logic signed [10:0] ey;
      logic signed [11:0] tx;
      logic signed [11:0] ty;
   } arm_pose_type;

   // one line of the directed table: either a register write or a request
   typedef struct packed {
      logic                               is_csr;
      logic [tlik_pkg::IDX_W-1:0]         idx;
      logic [tlik_pkg::DATA_W-1:0]        data;
      logic signed [tlik_pkg::STEP_W-1:0] sx;
      logic signed [tlik_pkg::STEP_W-1:0] sy;
      logic                               home;
      logic                               out_of_reach_zero;  // unreachable, zero held pose
   } stim_row_type;

   localparam int N_ROWS = 31;
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      // tiny arm, so the reset home is out of reach and nothing was solved yet
      '{1'b1, tlik_pkg::CSR_UPPER_LEN, 12'd1, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_LOWER_LEN, 12'd1, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd63, 7'sd63, 1'b0, 1'b1},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, -7'sd64, -7'sd64, 1'b0, 1'b1},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd0, 7'sd0, 1'b1, 1'b1},
      // home at origin with equal links, then close points
      '{1'b1, tlik_pkg::CSR_HOME_X, 12'd0, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_HOME_Y, 12'd0, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd5, 7'sd5, 1'b1, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd1, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, -7'sd1, -7'sd1, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, -7'sd1, 7'sd1, 1'b0, 1'b0},
      // zero link length, always out of reach, pose held
      '{1'b1, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd0, 7'sd0, 1'b0, 1'b0},
      // reset lengths, home at the coordinate corners, saturating jogs
      '{1'b1, tlik_pkg::CSR_UPPER_LEN, 12'd330, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_LOWER_LEN, 12'd350, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_HOME_X, 12'h7FF, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_HOME_Y, 12'h800, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd0, 7'sd0, 1'b1, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd63, -7'sd64, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_HOME_X, 12'h800, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_HOME_Y, 12'h7FF, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd0, 7'sd0, 1'b1, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, -7'sd64, 7'sd63, 1'b0, 1'b0},
      // back to the reset home, jog around it, x turning negative at the end
      '{1'b1, tlik_pkg::CSR_HOME_X, 12'd350, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_HOME_Y, 12'hF10, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd0, 7'sd0, 1'b1, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd63, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, 7'sd0, 7'sd63, 1'b0, 1'b0},
      '{1'b1, tlik_pkg::CSR_HOME_X, 12'hF00, 7'sd0, 7'sd0, 1'b0, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, -7'sd1, 7'sd1, 1'b1, 1'b0},
      '{1'b0, tlik_pkg::CSR_UPPER_LEN, 12'd0, -7'sd64, -7'sd1, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [tlik_pkg::STEP_W-1:0] req_step_x = '0;
   logic signed [tlik_pkg::STEP_W-1:0] req_step_y = '0;
   logic                               req_return_home = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_reachable;
   logic signed [15:0]                 rsp_shoulder_angle;
   logic signed [14:0]                 rsp_elbow_angle;
   logic signed [10:0]                 rsp_elbow_x;
   logic signed [10:0]                 rsp_elbow_y;
   logic signed [11:0]                 rsp_tip_x;
   logic signed [11:0]                 rsp_tip_y;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [tlik_pkg::IDX_W-1:0]         csr_index = '0;
   logic [tlik_pkg::DATA_W-1:0]        csr_wdata = '0;

   two_link_arm_inverse_kinematics dut (.*);

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // solver state: register copies, target position and last solved pose
   longint       link1 = 330, link2 = 350;
   longint       home_px = 350, home_py = -240;
   longint       aim_x = 350, aim_y = -240;
   arm_pose_type last_pose = '0;
   arm_pose_type pose_q[$];
   int           errors = 0;

   // idling mix of the current phase, in percent
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_request = 1'b0;
   bit  hold_used = 1'b0;
   int  hold_left = 0;

   function automatic longint clamp_coord(longint v);
      return v > 2047 ? 2047 : (v < -2048 ? -2048 : v);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // vectoring cordic, inputs prescaled, left half plane turned by pi first
   function automatic longint bearing(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * PRE_SCALE;
      y = y * PRE_SCALE;
      if (x < 0) begin
         z = (y >= 0) ? PI_A : -PI_A;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < N_ROT; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ARC_STEP[i];
         end else begin
            x -= ys; y += xs; z -= ARC_STEP[i];
         end
      end
      return z;
   endfunction

   function automatic longint q30_to_px(longint v, longint len);
      longint r;
      r = v >= 0 ? (v >>> 30) : -((-v) >>> 30);
      return r > len ? len : (r < -len ? -len : r);
   endfunction

   // rotation cordic giving len*cos and len*sin of z
   function automatic void project_link(input longint z, input longint len,
                                        output longint c, output longint s);
      bit     flip;
      longint x, y, xs, ys;
      flip = 1'b0;
      x = len * INV_GAIN;
      y = 0;
      repeat (2) if (z > PI_A) z -= TWO_PI_A;
      repeat (2) if (z < -PI_A) z += TWO_PI_A;
      if (z > HALF_PI_A) begin
         z -= PI_A; flip = 1'b1;
      end else if (z < -HALF_PI_A) begin
         z += PI_A; flip = 1'b1;
      end
      for (int i = 0; i < N_ROT; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= ARC_STEP[i];
         end else begin
            x += ys; y -= xs; z += ARC_STEP[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = q30_to_px(x, len);
      s = q30_to_px(y, len);
   endfunction

   function automatic longint to_q12(longint v);
      return (v + 2048) >>> 12;
   endfunction

   // moves the target and solves the arm, holding the pose when out of reach
   function automatic arm_pose_type solve_arm(logic signed [tlik_pkg::STEP_W-1:0] sx,
                                              logic signed [tlik_pkg::STEP_W-1:0] sy,
                                              logic home);
      longint       ax, ay, num, den, s, t2, p1, p2, q1, q2, ex, ey, fx, fy, sum_x, sum_y;
      arm_pose_type r;
      if (home) begin
         aim_x = clamp_coord(home_px);
         aim_y = clamp_coord(home_py);
      end else begin
         aim_x = clamp_coord(aim_x + longint'(sx));
         aim_y = clamp_coord(aim_y + longint'(sy));
      end
      ax = aim_x;
      ay = -aim_y;
      num = ax * ax + ay * ay - link1 * link1 - link2 * link2;
      den = 2 * link1 * link2;
      r = last_pose;
      r.reach = 1'b0;
      if (den != 0 && num <= den && num >= -den) begin
         s = longint'(root_floor(den * den - num * num));
         t2 = -bearing(s, num);
         p1 = bearing(ay, ax);
         p2 = bearing(-(link2 * s), link1 * den + link2 * num);
         q1 = to_q12(p1 - p2);
         q2 = to_q12(t2);
         project_link(q1 * 4096, link1, ex, ey);
         project_link((q1 + q2) * 4096, link2, fx, fy);
         sum_x = ex + fx;
         sum_y = ey + fy;
         r.reach = 1'b1;
         r.shoulder = q1[15:0];
         r.elbow = q2[14:0];
         r.ex = ex[10:0];
         r.ey = ey[10:0];
         r.tx = sum_x[11:0];
         r.ty = sum_y[11:0];
         last_pose = r;
         last_pose.reach = 1'b0;
      end
      return r;
   endfunction

   // waits for every outstanding result, then idles for a margin before returning
   task automatic drain();
      req_valid <= 1'b0;
      while (pose_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [tlik_pkg::IDX_W-1:0] idx,
                            logic [tlik_pkg::DATA_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         tlik_pkg::CSR_UPPER_LEN: link1 = longint'(data[tlik_pkg::LEN_W-1:0]);
         tlik_pkg::CSR_LOWER_LEN: link2 = longint'(data[tlik_pkg::LEN_W-1:0]);
         tlik_pkg::CSR_HOME_X:    home_px = longint'(signed'(data));
         tlik_pkg::CSR_HOME_Y:    home_py = longint'(signed'(data));
         default: ;
      endcase
   endtask

   // offers one request, with random idle cycles before it, and books its result
   task automatic send_request(logic signed [tlik_pkg::STEP_W-1:0] sx,
                               logic signed [tlik_pkg::STEP_W-1:0] sy,
                               logic home, bit zero_pose);
      arm_pose_type p;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_step_x <= sx;
      req_step_y <= sy;
      req_return_home <= home;
      do @(posedge clock); while (req_stall);
      p = solve_arm(sx, sy, home);
      if (zero_pose) p = '0;
      pose_q.push_back(p);
   endtask

   // receiver stall: random per phase, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_used) begin
         hold_left <= HOLD_OFF;
         hold_used <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
   end

   // result checker, field by field against the oldest booked pose
   always @(posedge clock) begin
      arm_pose_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_q.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            e = pose_q.pop_front();
            if (rsp_reachable !== e.reach) begin
               $error("reachable exp %0d got %0d", e.reach, rsp_reachable); errors++;
            end
            if (rsp_shoulder_angle !== e.shoulder) begin
               $error("shoulder_angle exp %0d got %0d", e.shoulder, rsp_shoulder_angle);
               errors++;
            end
            if (rsp_elbow_angle !== e.elbow) begin
               $error("elbow_angle exp %0d got %0d", e.elbow, rsp_elbow_angle); errors++;
            end
            if (rsp_elbow_x !== e.ex) begin
               $error("elbow_x exp %0d got %0d", e.ex, rsp_elbow_x); errors++;
            end
            if (rsp_elbow_y !== e.ey) begin
               $error("elbow_y exp %0d got %0d", e.ey, rsp_elbow_y); errors++;
            end
            if (rsp_tip_x !== e.tx) begin
               $error("tip_x exp %0d got %0d", e.tx, rsp_tip_x); errors++;
            end
            if (rsp_tip_y !== e.ty) begin
               $error("tip_y exp %0d got %0d", e.ty, rsp_tip_y); errors++;
            end
         end
      end
   end

   // main sequence
   initial begin
      int           per_phase;
      int           wait_cnt;
      logic         rh;
      stim_row_type row;
      per_phase = RND_ITEMS / N_PHASES;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, starting from the reset state
      foreach (DIRECTED[k]) begin
         row = DIRECTED[k];
         if (row.is_csr) write_reg(row.idx, row.data);
         else send_request(row.sx, row.sy, row.home, row.out_of_reach_zero);
      end

      // random phases; settings include the length extremes
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: begin
               write_reg(tlik_pkg::CSR_UPPER_LEN, 12'd1023);
               write_reg(tlik_pkg::CSR_LOWER_LEN, 12'd1023);
            end
            1: begin
               write_reg(tlik_pkg::CSR_UPPER_LEN, 12'd330);
               write_reg(tlik_pkg::CSR_LOWER_LEN, 12'd350);
            end
            2: begin
               write_reg(tlik_pkg::CSR_UPPER_LEN, 12'd1);
               write_reg(tlik_pkg::CSR_LOWER_LEN, 12'd1023);
            end
            3: begin
               write_reg(tlik_pkg::CSR_UPPER_LEN, 12'd1023);
               write_reg(tlik_pkg::CSR_LOWER_LEN, 12'd1);
            end
            4: begin
               write_reg(tlik_pkg::CSR_UPPER_LEN, 12'd600);
               write_reg(tlik_pkg::CSR_LOWER_LEN, 12'd600);
            end
            default: begin
               write_reg(tlik_pkg::CSR_UPPER_LEN, 12'($urandom_range(1023, 1)));
               write_reg(tlik_pkg::CSR_LOWER_LEN, 12'($urandom_range(1023, 1)));
            end
         endcase
         // keep home mostly within reach so jogs wander through solvable ground
         write_reg(tlik_pkg::CSR_HOME_X, 12'($urandom_range(1500) - 750));
         write_reg(tlik_pkg::CSR_HOME_Y,
                   (ph == 7) ? 12'($urandom) : 12'($urandom_range(1500) - 750));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         // long receiver hold-off while requests keep coming
         if (ph == 1) hold_request = 1'b1;
         for (int n = 0; n < per_phase; n++) begin
            rh = ($urandom_range(24) == 0);
            if ($urandom_range(3) == 0)
               send_request(7'($urandom), 7'($urandom), rh, 1'b0);
            else
               send_request(7'($urandom_range(16) - 8), 7'($urandom_range(16) - 8), rh, 1'b0);
         end
      end

      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_cnt = 0;
      while (pose_q.size() != 0 && wait_cnt < 200000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (200) @(posedge clock);
      if (errors == 0 && pose_q.size() == 0) begin
         $display("tb_two_link_arm_inverse_kinematics: done, clean");
      end else begin
         if (pose_q.size() != 0) $error("%0d results never arrived", pose_q.size());
         $display("tb_two_link_arm_inverse_kinematics: done, errors");
      end
      $finish;
   end

   // watchdog, several times the slowest expected run
   initial begin
      #100_000_000;
      $display("tb_two_link_arm_inverse_kinematics: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/tlik_pkg.sv
hw/rtl/tlik_ctrl.sv
hw/rtl/tlik_dp.sv
hw/rtl/two_link_arm_inverse_kinematics.sv
bench/tb_two_link_arm_inverse_kinematics.sv
